@@ rtl/dfps_pkg.sv @@
// Shared types, codes and helpers for the dual FIFO priority server.
`timescale 1ns / 1ps

package dfps_pkg;

   localparam logic [1:0] MODE_HIGH = 2'd0;
   localparam logic [1:0] MODE_LOW  = 2'd1;

   localparam logic [2:0] EV_HI_ADMIT  = 3'd0;
   localparam logic [2:0] EV_HI_REFUSE = 3'd1;
   localparam logic [2:0] EV_LO_ADMIT  = 3'd2;
   localparam logic [2:0] EV_LO_REFUSE = 3'd3;
   localparam logic [2:0] EV_HI_SERVE  = 3'd4;
   localparam logic [2:0] EV_LO_SERVE  = 3'd5;
   localparam logic [2:0] EV_IDLE      = 3'd6;

   localparam int NUM_TOTALS = 7;
   localparam logic [2:0] TOT_HI_SERVED  = 3'd0;
   localparam logic [2:0] TOT_LO_SERVED  = 3'd1;
   localparam logic [2:0] TOT_HI_REFUSED = 3'd2;
   localparam logic [2:0] TOT_LO_REFUSED = 3'd3;
   localparam logic [2:0] TOT_HI_WAIT    = 3'd4;
   localparam logic [2:0] TOT_LO_WAIT    = 3'd5;
   localparam logic [2:0] TOT_IDLE       = 3'd6;

   localparam logic [4:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic load;
      logic exec;
   } dfps_cmd_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

@@ rtl/dual_fifo_priority_server_core.sv @@
// The result strobe is registered at the end of the execute state that follows the edge
// that accepts a request; the result registers are loaded at the same edge.
// A new request is not accepted while busy; busy is high for the execute state, in which
// the registered head read of each queue memory is consumed and the queues updated.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset (synchronous): queues empty, totals zero, queue limit 16; no clearing pass.
`timescale 1ns / 1ps

module dual_fifo_priority_server_core
   import dfps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [15:0]      req_flight_id,
   input  logic [31:0]      req_now,
   input  logic             csr_write_en,
   input  logic [4:0]       csr_write_data,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_event_kind,
   output logic [15:0]      rsp_served_id,
   output logic [31:0]      rsp_wait_time,
   output logic [4:0]       rsp_high_occupancy,
   output logic [4:0]       rsp_low_occupancy,
   output logic [31:0]      rsp_high_served_total,
   output logic [31:0]      rsp_low_served_total,
   output logic [31:0]      rsp_high_refused_total,
   output logic [31:0]      rsp_low_refused_total,
   output logic [31:0]      rsp_high_wait_total,
   output logic [31:0]      rsp_low_wait_total,
   output logic [31:0]      rsp_idle_total
);

   dfps_cmd_type cmd;

   dfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   dfps_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_write_en           (csr_write_en),
      .csr_write_data         (csr_write_data),
      .req_mode               (req_mode),
      .req_flight_id          (req_flight_id),
      .req_now                (req_now),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_served_id          (rsp_served_id),
      .rsp_wait_time          (rsp_wait_time),
      .rsp_high_occupancy     (rsp_high_occupancy),
      .rsp_low_occupancy      (rsp_low_occupancy),
      .rsp_high_served_total  (rsp_high_served_total),
      .rsp_low_served_total   (rsp_low_served_total),
      .rsp_high_refused_total (rsp_high_refused_total),
      .rsp_low_refused_total  (rsp_low_refused_total),
      .rsp_high_wait_total    (rsp_high_wait_total),
      .rsp_low_wait_total     (rsp_low_wait_total),
      .rsp_idle_total         (rsp_idle_total)
   );

endmodule

@@ rtl/dfps_ctrl.sv @@
// Controller state machine: request acceptance, execute step and result strobe.
`timescale 1ns / 1ps

module dfps_ctrl
   import dfps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output dfps_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   always_comb begin
      cmd.load  = start && (state_ff == ST_IDLE);
      cmd.exec  = (state_ff == ST_EXEC);
      strobe_in = cmd.exec;
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule

@@ rtl/dfps_datapath.sv @@
// Datapath: both queues, limit register, totals and result registers.
`timescale 1ns / 1ps

module dfps_datapath
   import dfps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  dfps_cmd_type     cmd,
   input  logic             csr_write_en,
   input  logic [4:0]       csr_write_data,
   input  logic [1:0]       req_mode,
   input  logic [15:0]      req_flight_id,
   input  logic [31:0]      req_now,
   output logic [2:0]       rsp_event_kind,
   output logic [15:0]      rsp_served_id,
   output logic [31:0]      rsp_wait_time,
   output logic [4:0]       rsp_high_occupancy,
   output logic [4:0]       rsp_low_occupancy,
   output logic [31:0]      rsp_high_served_total,
   output logic [31:0]      rsp_low_served_total,
   output logic [31:0]      rsp_high_refused_total,
   output logic [31:0]      rsp_low_refused_total,
   output logic [31:0]      rsp_high_wait_total,
   output logic [31:0]      rsp_low_wait_total,
   output logic [31:0]      rsp_idle_total
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(QUEUE_DEPTH);

   logic [15:0] high_ids_ff [QUEUE_DEPTH];
   logic [31:0] high_arr_ff [QUEUE_DEPTH];
   logic [15:0] low_ids_ff  [QUEUE_DEPTH];
   logic [31:0] low_arr_ff  [QUEUE_DEPTH];

   logic [15:0] hrd_id_ff, lrd_id_ff;
   logic [31:0] hrd_arr_ff, lrd_arr_ff;

   logic [4:0]       limit_ff;
   logic [1:0]       mode_ff;
   logic [15:0]      id_ff;
   logic [31:0]      now_ff;

   logic [PTR_W-1:0] hhead_ff, hhead_in, htail_ff, htail_in;
   logic [PTR_W-1:0] lhead_ff, lhead_in, ltail_ff, ltail_in;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in, lcnt_ff, lcnt_in;
   logic [31:0]      tot_ff [NUM_TOTALS];
   logic [31:0]      tot_in [NUM_TOTALS];

   logic [2:0]  kind_ff, kind_in;
   logic [15:0] rid_ff, rid_in;
   logic [31:0] wait_ff, wait_in;

   logic [LIM_W-1:0] lim;
   logic             hi_wr, lo_wr;

   always_comb begin
      priority if (limit_ff == 5'd0) begin
         lim = LIM_W'(1);
      end else if (LIM_W'(limit_ff) > LIM_MAX) begin
         lim = LIM_MAX;
      end else begin
         lim = LIM_W'(limit_ff);
      end
   end

   always_comb begin
      hhead_in = hhead_ff;
      htail_in = htail_ff;
      lhead_in = lhead_ff;
      ltail_in = ltail_ff;
      hcnt_in  = hcnt_ff;
      lcnt_in  = lcnt_ff;
      for (int i = 0; i < NUM_TOTALS; i++) tot_in[i] = tot_ff[i];
      kind_in  = EV_IDLE;
      rid_in   = 16'd0;
      wait_in  = 32'd0;
      hi_wr    = 1'b0;
      lo_wr    = 1'b0;
      if (mode_ff == MODE_HIGH) begin
         rid_in = id_ff;
         if (LIM_W'(hcnt_ff) >= lim) begin
            kind_in = EV_HI_REFUSE;
            tot_in[TOT_HI_REFUSED] = sat_add(tot_ff[TOT_HI_REFUSED], 32'd1);
         end else begin
            kind_in  = EV_HI_ADMIT;
            hi_wr    = 1'b1;
            htail_in = (htail_ff == PTR_LAST) ? '0 : htail_ff + PTR_W'(1);
            hcnt_in  = hcnt_ff + CNT_W'(1);
         end
      end else if (mode_ff == MODE_LOW) begin
         rid_in = id_ff;
         if (LIM_W'(lcnt_ff) >= lim) begin
            kind_in = EV_LO_REFUSE;
            tot_in[TOT_LO_REFUSED] = sat_add(tot_ff[TOT_LO_REFUSED], 32'd1);
         end else begin
            kind_in  = EV_LO_ADMIT;
            lo_wr    = 1'b1;
            ltail_in = (ltail_ff == PTR_LAST) ? '0 : ltail_ff + PTR_W'(1);
            lcnt_in  = lcnt_ff + CNT_W'(1);
         end
      end else if (hcnt_ff != '0) begin
         kind_in  = EV_HI_SERVE;
         rid_in   = hrd_id_ff;
         wait_in  = now_ff - hrd_arr_ff;
         hhead_in = (hhead_ff == PTR_LAST) ? '0 : hhead_ff + PTR_W'(1);
         hcnt_in  = hcnt_ff - CNT_W'(1);
         tot_in[TOT_HI_SERVED] = sat_add(tot_ff[TOT_HI_SERVED], 32'd1);
         tot_in[TOT_HI_WAIT]   = sat_add(tot_ff[TOT_HI_WAIT], now_ff - hrd_arr_ff);
      end else if (lcnt_ff != '0) begin
         kind_in  = EV_LO_SERVE;
         rid_in   = lrd_id_ff;
         wait_in  = now_ff - lrd_arr_ff;
         lhead_in = (lhead_ff == PTR_LAST) ? '0 : lhead_ff + PTR_W'(1);
         lcnt_in  = lcnt_ff - CNT_W'(1);
         tot_in[TOT_LO_SERVED] = sat_add(tot_ff[TOT_LO_SERVED], 32'd1);
         tot_in[TOT_LO_WAIT]   = sat_add(tot_ff[TOT_LO_WAIT], now_ff - lrd_arr_ff);
      end else begin
         tot_in[TOT_IDLE] = sat_add(tot_ff[TOT_IDLE], 32'd1);
      end
   end

   // queue storage, head read registered every cycle
   always_ff @(posedge clock) begin
      if (cmd.exec && hi_wr) begin
         high_ids_ff[htail_ff] <= id_ff;
         high_arr_ff[htail_ff] <= now_ff;
      end
      if (cmd.exec && lo_wr) begin
         low_ids_ff[ltail_ff] <= id_ff;
         low_arr_ff[ltail_ff] <= now_ff;
      end
      hrd_id_ff  <= high_ids_ff[hhead_ff];
      hrd_arr_ff <= high_arr_ff[hhead_ff];
      lrd_id_ff  <= low_ids_ff[lhead_ff];
      lrd_arr_ff <= low_arr_ff[lhead_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_flight_id;
         now_ff  <= req_now;
      end
      if (cmd.exec) begin
         kind_ff <= kind_in;
         rid_ff  <= rid_in;
         wait_ff <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         hhead_ff <= '0;
         htail_ff <= '0;
         lhead_ff <= '0;
         ltail_ff <= '0;
         hcnt_ff  <= '0;
         lcnt_ff  <= '0;
         for (int i = 0; i < NUM_TOTALS; i++) tot_ff[i] <= 32'd0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (cmd.exec) begin
            hhead_ff <= hhead_in;
            htail_ff <= htail_in;
            lhead_ff <= lhead_in;
            ltail_ff <= ltail_in;
            hcnt_ff  <= hcnt_in;
            lcnt_ff  <= lcnt_in;
            for (int i = 0; i < NUM_TOTALS; i++) tot_ff[i] <= tot_in[i];
         end
      end
   end

   assign rsp_event_kind         = kind_ff;
   assign rsp_served_id          = rid_ff;
   assign rsp_wait_time          = wait_ff;
   assign rsp_high_occupancy     = 5'(hcnt_ff);
   assign rsp_low_occupancy      = 5'(lcnt_ff);
   assign rsp_high_served_total  = tot_ff[TOT_HI_SERVED];
   assign rsp_low_served_total   = tot_ff[TOT_LO_SERVED];
   assign rsp_high_refused_total = tot_ff[TOT_HI_REFUSED];
   assign rsp_low_refused_total  = tot_ff[TOT_LO_REFUSED];
   assign rsp_high_wait_total    = tot_ff[TOT_HI_WAIT];
   assign rsp_low_wait_total     = tot_ff[TOT_LO_WAIT];
   assign rsp_idle_total         = tot_ff[TOT_IDLE];

endmodule

@@ sim/dual_fifo_priority_server_core_tb.sv @@
// Self-checking testbench for the dual FIFO priority server: directed and random requests.
`timescale 1ns / 1ps

module dual_fifo_priority_server_core_tb
   import dfps_pkg::*;
();

   localparam int         DEPTH          = 16;
   localparam logic [1:0] MODE_TICK      = 2'd2;
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         PHASE_ITEMS    = 66;

   typedef struct packed {
      logic [2:0]                  kind;
      logic [15:0]                 id;
      logic [31:0]                 waited;
      logic [4:0]                  hi_occ;
      logic [4:0]                  lo_occ;
      logic [NUM_TOTALS-1:0][31:0] totals;
   } outcome_type;

   class flight_scoreboard_type;
      logic [4:0]  limit;
      logic [15:0] ids[2][DEPTH];
      logic [31:0] arrivals[2][DEPTH];
      int          head[2];
      int          tail[2];
      int          count[2];
      logic [31:0] totals[NUM_TOTALS];
      string       total_names[NUM_TOTALS];
      outcome_type awaited[$];
      int          errors;

      function new();
         limit  = LIMIT_RESET;
         errors = 0;
         for (int q = 0; q < 2; q++) begin
            head[q]  = 0;
            tail[q]  = 0;
            count[q] = 0;
         end
         foreach (totals[j]) totals[j] = '0;
         total_names = '{"high_served_total", "low_served_total", "high_refused_total",
                         "low_refused_total", "high_wait_total", "low_wait_total",
                         "idle_total"};
      endfunction

      function logic [31:0] capped_sum(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function void set_limit(logic [4:0] v);
         limit = v;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(logic [1:0] mode, logic [15:0] fid, logic [31:0] now);
         outcome_type r;
         int          q;
         int          cap;
         r   = '0;
         cap = (limit == 0) ? 1 : ((limit > DEPTH) ? DEPTH : int'(limit));
         if (mode == MODE_HIGH || mode == MODE_LOW) begin
            q    = (mode == MODE_HIGH) ? 0 : 1;
            r.id = fid;
            if (count[q] < cap) begin
               ids[q][tail[q]]      = fid;
               arrivals[q][tail[q]] = now;
               tail[q]              = (tail[q] + 1) % DEPTH;
               count[q]++;
               r.kind = (q == 0) ? EV_HI_ADMIT : EV_LO_ADMIT;
            end else if (q == 0) begin
               r.kind = EV_HI_REFUSE;
               totals[TOT_HI_REFUSED] = capped_sum(totals[TOT_HI_REFUSED], 32'd1);
            end else begin
               r.kind = EV_LO_REFUSE;
               totals[TOT_LO_REFUSED] = capped_sum(totals[TOT_LO_REFUSED], 32'd1);
            end
         end else if (count[0] == 0 && count[1] == 0) begin
            r.kind = EV_IDLE;
            totals[TOT_IDLE] = capped_sum(totals[TOT_IDLE], 32'd1);
         end else begin
            q        = (count[0] > 0) ? 0 : 1;
            r.id     = ids[q][head[q]];
            r.waited = now - arrivals[q][head[q]];
            head[q]  = (head[q] + 1) % DEPTH;
            count[q]--;
            if (q == 0) begin
               r.kind = EV_HI_SERVE;
               totals[TOT_HI_SERVED] = capped_sum(totals[TOT_HI_SERVED], 32'd1);
               totals[TOT_HI_WAIT]   = capped_sum(totals[TOT_HI_WAIT], r.waited);
            end else begin
               r.kind = EV_LO_SERVE;
               totals[TOT_LO_SERVED] = capped_sum(totals[TOT_LO_SERVED], 32'd1);
               totals[TOT_LO_WAIT]   = capped_sum(totals[TOT_LO_WAIT], r.waited);
            end
         end
         r.hi_occ = 5'(count[0]);
         r.lo_occ = 5'(count[1]);
         for (int j = 0; j < NUM_TOTALS; j++) r.totals[j] = totals[j];
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      endtask

      task check_result(outcome_type got);
         outcome_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result with no request waiting", 32'(got.kind), '0);
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("event_kind", 32'(got.kind), 32'(want.kind));
         if (got.id !== want.id)
            report_mismatch("served_id", 32'(got.id), 32'(want.id));
         if (got.waited !== want.waited) report_mismatch("wait_time", got.waited, want.waited);
         if (got.hi_occ !== want.hi_occ)
            report_mismatch("high_occupancy", 32'(got.hi_occ), 32'(want.hi_occ));
         if (got.lo_occ !== want.lo_occ)
            report_mismatch("low_occupancy", 32'(got.lo_occ), 32'(want.lo_occ));
         for (int j = 0; j < NUM_TOTALS; j++)
            if (got.totals[j] !== want.totals[j])
               report_mismatch(total_names[j], got.totals[j], want.totals[j]);
      endtask
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic [1:0]  req_mode       = '0;
   logic [15:0] req_flight_id  = '0;
   logic [31:0] req_now        = '0;
   logic        csr_write_en   = 1'b0;
   logic [4:0]  csr_write_data = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [2:0]  rsp_event_kind;
   logic [15:0] rsp_served_id;
   logic [31:0] rsp_wait_time;
   logic [4:0]  rsp_high_occupancy;
   logic [4:0]  rsp_low_occupancy;
   logic [31:0] rsp_high_served_total;
   logic [31:0] rsp_low_served_total;
   logic [31:0] rsp_high_refused_total;
   logic [31:0] rsp_low_refused_total;
   logic [31:0] rsp_high_wait_total;
   logic [31:0] rsp_low_wait_total;
   logic [31:0] rsp_idle_total;

   flight_scoreboard_type sb;
   outcome_type           seen;
   logic [31:0]           timeline = '0;
   int                    idle_cycles = 0;

   dual_fifo_priority_server_core #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_mode               (req_mode),
      .req_flight_id          (req_flight_id),
      .req_now                (req_now),
      .csr_write_en           (csr_write_en),
      .csr_write_data         (csr_write_data),
      .rsp_strobe             (rsp_strobe),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_served_id          (rsp_served_id),
      .rsp_wait_time          (rsp_wait_time),
      .rsp_high_occupancy     (rsp_high_occupancy),
      .rsp_low_occupancy      (rsp_low_occupancy),
      .rsp_high_served_total  (rsp_high_served_total),
      .rsp_low_served_total   (rsp_low_served_total),
      .rsp_high_refused_total (rsp_high_refused_total),
      .rsp_low_refused_total  (rsp_low_refused_total),
      .rsp_high_wait_total    (rsp_high_wait_total),
      .rsp_low_wait_total     (rsp_low_wait_total),
      .rsp_idle_total         (rsp_idle_total)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen = {rsp_event_kind, rsp_served_id, rsp_wait_time, rsp_high_occupancy,
                 rsp_low_occupancy, rsp_idle_total, rsp_low_wait_total, rsp_high_wait_total,
                 rsp_low_refused_total, rsp_high_refused_total, rsp_low_served_total,
                 rsp_high_served_total};
         sb.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("dual_fifo_priority_server_core_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [15:0] fid,
                               input logic [31:0] now);
      @(negedge clock);
      start         <= 1'b1;
      req_mode      <= mode;
      req_flight_id <= fid;
      req_now       <= now;
      do @(posedge clock); while (busy);
      sb.note_request(mode, fid, now);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_results();
      pause_sender(1);
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [4:0] value);
      drain_results();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_limit(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_phase(input logic [4:0] value, input int tick_pct, input int items);
      int          burst;
      int          gap;
      logic [1:0]  mode;
      logic [15:0] fid;
      write_limit(value);
      burst = $urandom_range(1, 16);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            mode = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_TICK;
         else
            mode = $urandom_range(0, 1) ? MODE_LOW : MODE_HIGH;
         fid = 16'($urandom_range(0, 65535));
         // occasional jumps make large waits, time reversal and wait-total saturation
         if ($urandom_range(0, 9) == 0)
            timeline = $urandom;
         else
            timeline = timeline + $urandom_range(0, 20);
         send_request(mode, fid, timeline);
         burst--;
         if (burst == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            pause_sender(gap);
            burst = $urandom_range(1, 16);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queues, both tick codes, field extremes, time going backwards
      send_request(MODE_TICK,  16'h0000, 32'h0000_0000);
      send_request(MODE_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(MODE_HIGH,  16'h0000, 32'h0000_0000);
      send_request(MODE_HIGH,  16'hFFFF, 32'hFFFF_FFFF);
      send_request(MODE_LOW,   16'h1234, 32'h0000_0007);
      send_request(MODE_SPARE, 16'h0000, 32'h0000_0005);
      send_request(MODE_TICK,  16'h0000, 32'h0000_0003);
      send_request(MODE_TICK,  16'h0000, 32'h0000_0064);
      send_request(MODE_TICK,  16'h0000, 32'h0000_0000);

      // limit of zero behaves as one
      write_limit(5'd0);
      send_request(MODE_HIGH, 16'h0001, 32'd10);
      send_request(MODE_HIGH, 16'h0002, 32'd11);
      send_request(MODE_LOW,  16'hAAAA, 32'd12);
      send_request(MODE_LOW,  16'h5555, 32'd13);

      write_limit(5'd2);
      send_request(MODE_HIGH, 16'h0003, 32'd20);
      send_request(MODE_HIGH, 16'h0004, 32'd21);

      // limit lowered below the current fill
      write_limit(5'd1);
      send_request(MODE_HIGH, 16'h0005, 32'd22);
      send_request(MODE_TICK, 16'h0000, 32'd30);
      send_request(MODE_HIGH, 16'h0006, 32'd31);
      send_request(MODE_TICK, 16'h0000, 32'd40);
      send_request(MODE_HIGH, 16'h0007, 32'd41);
      send_request(MODE_TICK, 16'h0000, 32'd50);
      send_request(MODE_TICK, 16'h0000, 32'd60);
      send_request(MODE_TICK, 16'h0000, 32'd70);

      timeline = 32'd100;
      random_phase(5'd31, 30, PHASE_ITEMS);
      random_phase(5'd16, 45, PHASE_ITEMS);
      random_phase(5'd1,  50, PHASE_ITEMS);
      random_phase(5'd0,  40, PHASE_ITEMS);
      random_phase(5'd2,  35, PHASE_ITEMS);
      random_phase(5'd17, 25, PHASE_ITEMS);
      random_phase(5'd3,  55, PHASE_ITEMS);
      random_phase(5'($urandom_range(0, 31)), 40, PHASE_ITEMS);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("dual_fifo_priority_server_core_tb: done, clean");
      else
         $display("dual_fifo_priority_server_core_tb: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/dfps_pkg.sv
rtl/dfps_ctrl.sv
rtl/dfps_datapath.sv
rtl/dual_fifo_priority_server_core.sv
sim/dual_fifo_priority_server_core_tb.sv
